>>> rtl/core/fde_pkg.sv
`timescale 1ns / 1ps
// fde_pkg: shared types, codes and constants of the FAT directory entry decoder.
// No dependencies.

package fde_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_SKIP  = 2'd0;
    localparam kind_t KIND_FILE  = 2'd1;
    localparam kind_t KIND_END   = 2'd2;
    localparam kind_t KIND_CHAR  = 2'd3;

    localparam logic OP_ENTRY = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [7:0]  BYTE_END     = 8'h00;
    localparam logic [7:0]  BYTE_DELETED = 8'hE5;
    localparam logic [7:0]  BYTE_PAD     = 8'h20;
    localparam logic [3:0]  ATTR_LFN     = 4'hF;
    localparam logic [15:0] UNIT_FILL    = 16'hFFFF;
    localparam logic [15:0] UNIT_NUL     = 16'h0000;
    localparam logic [15:0] UNIT_DOT     = 16'h002E;
    localparam logic [11:0] YEAR_BASE    = 12'd1980;
    localparam int          LFN_UNITS    = 13;

    typedef logic [255:0] entry_t;

    // byte offsets of the 13 UTF-16 units of one long-name part
    localparam logic [4:0] LFN_OFFS [LFN_UNITS] = '{
        5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16,
        5'd18, 5'd20, 5'd22, 5'd24, 5'd28, 5'd30
    };

    typedef struct packed {
        kind_t       result_kind;
        logic [7:0]  attributes;
        logic [31:0] file_size;
        logic [4:0]  mod_day;
        logic [3:0]  mod_month;
        logic [11:0] mod_year;
        logic [4:0]  mod_hours;
        logic [5:0]  mod_minutes;
        logic [5:0]  mod_seconds;
        logic [7:0]  name_length;
        logic [15:0] name_char;
    } rsp_word_t;

    function automatic logic [15:0] part_unit(input entry_t e, input logic [3:0] j);
        logic [4:0] off;
        off = (j < 4'(LFN_UNITS)) ? LFN_OFFS[j] : 5'd0;
        return e[{off, 3'b000} +: 16];
    endfunction

    // units up to the first 0 or 0xFFFF
    function automatic logic [3:0] part_len(input entry_t e);
        logic [3:0]  n;
        logic        stop;
        logic [15:0] u;
        n    = 4'(LFN_UNITS);
        stop = 1'b0;
        for (int i = 0; i < LFN_UNITS; i++)
        begin
            u = e[{LFN_OFFS[i], 3'b000} +: 16];
            if (!stop && (u == UNIT_NUL || u == UNIT_FILL))
            begin
                n    = 4'(i);
                stop = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

>>> rtl/core/fde_if.sv
`timescale 1ns / 1ps
// fde_if: request and response channels of the directory entry decoder.
// Depends on fde_pkg.

interface fde_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [63:0] entry_word0;
    logic [63:0] entry_word1;
    logic [63:0] entry_word2;
    logic [63:0] entry_word3;
    logic [7:0]  char_index;

    modport source (output valid, opcode, entry_word0, entry_word1, entry_word2,
                    entry_word3, char_index, input ready);
    modport sink   (input valid, opcode, entry_word0, entry_word1, entry_word2,
                    entry_word3, char_index, output ready);
endinterface

interface fde_rsp_if;
    logic                valid;
    logic                ready;
    fde_pkg::kind_t      result_kind;
    logic [7:0]          attributes;
    logic [31:0]         file_size;
    logic [4:0]          mod_day;
    logic [3:0]          mod_month;
    logic [11:0]         mod_year;
    logic [4:0]          mod_hours;
    logic [5:0]          mod_minutes;
    logic [5:0]          mod_seconds;
    logic [7:0]          name_length;
    logic [15:0]         name_char;

    modport source (output valid, result_kind, attributes, file_size, mod_day, mod_month,
                    mod_year, mod_hours, mod_minutes, mod_seconds, name_length,
                    name_char, input ready);
    modport sink   (input valid, result_kind, attributes, file_size, mod_day, mod_month,
                    mod_year, mod_hours, mod_minutes, mod_seconds, name_length,
                    name_char, output ready);
endinterface

>>> rtl/core/fde_ram.sv
`timescale 1ns / 1ps
// fde_ram: generic RAM, one write port, one read port with registered data.
// No dependencies.

module fde_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/fat_directory_entry_decoder.sv
`timescale 1ns / 1ps
// fat_directory_entry_decoder: decodes FAT directory entries, builds names in a RAM.
// Depends on fde_pkg, fde_if (fde_req_if, fde_rsp_if) and fde_ram.
//
//  channel | dir | word
//  --------+-----+-------------------------------------------------------------
//  req     | in  | opcode, entry_word0..3 (32-byte entry, LE), char_index
//  rsp     | out | result_kind, attributes, file_size, date/time, length, char
//
// A read does its RAM read as the word is accepted, then the result. Skipped, deleted,
// end and long-name-pending short entries go straight to the result. A long-name
// part first writes its n units (n <= 13); a plain 8.3 entry writes its 8 base
// bytes, then for a non-empty extension a dot and up to 3 units, one RAM write a cycle.
// One item is in flight at a time; req.ready is high only when idle.
// The result sits in an output register, so the next word may be accepted
// while rsp is stalled; a finished item waits there only for that register.
// Reset clears control state only; the name RAM needs no clearing pass since
// a name slot is always written before it can be read.

module fat_directory_entry_decoder #(
    parameter int NAME_SLOTS = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    fde_req_if.sink   req,
    fde_rsp_if.source rsp
);

    import fde_pkg::*;

    localparam int AW       = $clog2(NAME_SLOTS);
    localparam int PW       = (AW > 9) ? AW : 9;
    localparam int NAME_CAP = ((NAME_SLOTS - 1) < 255) ? (NAME_SLOTS - 1) : 255;
    localparam logic [8:0] CAP9 = 9'(NAME_CAP);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LONG  = 2'd1;
    localparam logic [1:0] S_SHORT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]  state_reg, state_next;
    entry_t      entry_reg, entry_next;
    kind_t       kind_reg, kind_next;
    logic        char_ok_reg, char_ok_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [3:0]  plen_reg, plen_next;
    logic [7:0]  total_reg, total_next;
    logic [7:0]  start_reg, start_next;
    logic [7:0]  len_reg, len_next;
    logic        pending_reg, pending_next;
    logic        ended_reg, ended_next;
    logic        rsp_valid_reg, rsp_valid_next;
    rsp_word_t   out_reg, out_next;

    entry_t      req_entry;
    logic        accept;
    logic [3:0]  req_plen;
    logic [8:0]  base9, total9;
    logic [PW-1:0] rd_pos, long_pos;
    logic        out_free;

    // short-name bookkeeping, from the latched entry
    logic [3:0]  sn_last;
    logic [1:0]  sn_ext;
    logic [3:0]  sn_writes;
    logic [3:0]  sn_len;
    logic [3:0]  sn_addr;
    logic [15:0] sn_data;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [15:0]      ram_wdata, ram_rdata;

    logic [15:0] tm, dt;

    assign req_entry = {req.entry_word3, req.entry_word2, req.entry_word1, req.entry_word0};
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign req_plen  = part_len(req_entry);
    assign base9     = pending_reg ? {1'b0, len_reg} : 9'd0;
    assign total9    = base9 + {5'd0, req_plen};
    assign rd_pos    = PW'(start_reg) + PW'(req.char_index);
    assign long_pos  = PW'(CAP9 - {1'b0, total_reg}) + PW'(cnt_reg);
    assign out_free  = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        sn_last = 4'd0;
        for (int c = 0; c < 8; c++)
        begin
            if (entry_reg[8*c +: 8] > BYTE_PAD)
            begin
                sn_last = 4'(c + 1);
            end
        end
        if (entry_reg[71:64] <= BYTE_PAD)
            sn_ext = 2'd0;
        else if (entry_reg[79:72] <= BYTE_PAD)
            sn_ext = 2'd1;
        else if (entry_reg[87:80] <= BYTE_PAD)
            sn_ext = 2'd2;
        else
            sn_ext = 2'd3;
        sn_writes = (sn_ext == 2'd0) ? 4'd8 : 4'd9 + {2'd0, sn_ext};
        sn_len    = (sn_ext == 2'd0) ? sn_last : sn_last + {2'd0, sn_ext} + 4'd1;
        // base bytes to slots 0..7, then dot at last, then extension units
        if (cnt_reg < 4'd8)
        begin
            sn_addr = cnt_reg;
            sn_data = {8'h00, entry_reg[{cnt_reg, 3'b000} +: 8]};
        end
        else if (cnt_reg == 4'd8)
        begin
            sn_addr = sn_last;
            sn_data = UNIT_DOT;
        end
        else
        begin
            sn_addr = sn_last + (cnt_reg - 4'd8);
            sn_data = {8'h00, entry_reg[{cnt_reg - 4'd1, 3'b000} +: 8]};
        end
    end

    assign ram_re    = accept && (req.opcode == OP_READ);
    assign ram_raddr = rd_pos[AW-1:0];
    assign ram_we    = (state_reg == S_LONG) || (state_reg == S_SHORT);
    assign ram_waddr = (state_reg == S_LONG) ? long_pos[AW-1:0] : AW'(sn_addr);
    assign ram_wdata = (state_reg == S_LONG) ? part_unit(entry_reg, cnt_reg) : sn_data;

    fde_ram #(
        .WIDTH (16),
        .DEPTH (NAME_SLOTS)
    ) u_name_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign tm = entry_reg[191:176];
    assign dt = entry_reg[207:192];

    always_comb
    begin
        state_next     = state_reg;
        entry_next     = entry_reg;
        kind_next      = kind_reg;
        char_ok_next   = char_ok_reg;
        cnt_next       = cnt_reg;
        plen_next      = plen_reg;
        total_next     = total_reg;
        start_next     = start_reg;
        len_next       = len_reg;
        pending_next   = pending_reg;
        ended_next     = ended_reg;
        rsp_valid_next = rsp_valid_reg;
        out_next       = out_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    entry_next   = req_entry;
                    cnt_next     = 4'd0;
                    state_next   = S_DONE;
                    kind_next    = KIND_SKIP;
                    char_ok_next = ({1'b0, req.char_index} < {1'b0, len_reg});
                    if (req.opcode == OP_READ)
                    begin
                        kind_next = KIND_CHAR;
                    end
                    else if (ended_reg)
                    begin
                        kind_next = KIND_END;
                    end
                    else if (req_entry[7:0] == BYTE_END)
                    begin
                        ended_next = 1'b1;
                        kind_next  = KIND_END;
                    end
                    else if (req_entry[7:0] == BYTE_DELETED)
                    begin
                        kind_next = KIND_SKIP;
                    end
                    else if (req_entry[91:88] == ATTR_LFN)
                    begin
                        // long-name part: a fresh name starts empty at the top
                        if (!pending_reg)
                        begin
                            pending_next = 1'b1;
                            len_next     = 8'd0;
                            start_next   = 8'(NAME_CAP);
                        end
                        if (total9 <= CAP9)
                        begin
                            plen_next  = req_plen;
                            total_next = total9[7:0];
                            if (req_plen == 4'd0)
                            begin
                                len_next   = total9[7:0];
                                start_next = 8'(CAP9 - total9);
                            end
                            else
                            begin
                                state_next = S_LONG;
                            end
                        end
                    end
                    else
                    begin
                        kind_next = KIND_FILE;
                        if (pending_reg)
                            pending_next = 1'b0;
                        else
                            state_next = S_SHORT;
                    end
                end
            end
            S_LONG:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == plen_reg - 4'd1)
                begin
                    len_next   = total_reg;
                    start_next = 8'(CAP9 - {1'b0, total_reg});
                    state_next = S_DONE;
                end
            end
            S_SHORT:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == sn_writes - 4'd1)
                begin
                    len_next   = {4'd0, sn_len};
                    start_next = 8'd0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next             = '0;
                    out_next.result_kind = kind_reg;
                    if (kind_reg == KIND_FILE)
                    begin
                        out_next.attributes  = entry_reg[95:88];
                        out_next.file_size   = entry_reg[255:224];
                        out_next.mod_day     = dt[4:0];
                        out_next.mod_month   = dt[8:5];
                        out_next.mod_year    = {5'd0, dt[15:9]} + YEAR_BASE;
                        out_next.mod_hours   = tm[15:11];
                        out_next.mod_minutes = tm[10:5];
                        out_next.mod_seconds = {tm[4:0], 1'b0};
                        out_next.name_length = len_reg;
                    end
                    if (kind_reg == KIND_CHAR && char_ok_reg)
                    begin
                        out_next.name_char = ram_rdata;
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 8'd0;
            len_reg       <= 8'd0;
            pending_reg   <= 1'b0;
            ended_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
            cnt_reg       <= 4'd0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            len_reg       <= len_next;
            pending_reg   <= pending_next;
            ended_reg     <= ended_next;
            rsp_valid_reg <= rsp_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg   <= entry_next;
        kind_reg    <= kind_next;
        char_ok_reg <= char_ok_next;
        plen_reg    <= plen_next;
        total_reg   <= total_next;
        out_reg     <= out_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.result_kind = out_reg.result_kind;
    assign rsp.attributes  = out_reg.attributes;
    assign rsp.file_size   = out_reg.file_size;
    assign rsp.mod_day     = out_reg.mod_day;
    assign rsp.mod_month   = out_reg.mod_month;
    assign rsp.mod_year    = out_reg.mod_year;
    assign rsp.mod_hours   = out_reg.mod_hours;
    assign rsp.mod_minutes = out_reg.mod_minutes;
    assign rsp.mod_seconds = out_reg.mod_seconds;
    assign rsp.name_length = out_reg.name_length;
    assign rsp.name_char   = out_reg.name_char;

    // name always fits below the cap
    a_name_fits: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, start_reg} + {1'b0, len_reg}) <= CAP9)
        else $error("name extends past cap");

    // long-part writes never exceed the part length
    a_long_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LONG) |-> (cnt_reg < plen_reg) && (plen_reg != 4'd0))
        else $error("long part write count out of range");

    // a new result only appears after the done state
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response raised outside done state");

    // a held response is never overwritten
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |=> $stable(out_reg))
        else $error("stalled response changed");

    // end of directory is sticky
    a_end_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ended_reg |=> ended_reg)
        else $error("end marker cleared");

endmodule

>>> verif/fat_directory_entry_decoder_tb.sv
`timescale 1ns / 1ps
// fat_directory_entry_decoder_tb: self-checking bench for the FAT directory entry decoder.
// Depends on fde_pkg, fde_if (fde_req_if, fde_rsp_if) and fat_directory_entry_decoder.

module fat_directory_entry_decoder_tb;

    import fde_pkg::*;

    localparam int NAME_SLOTS   = 256;
    localparam int NAME_CAP     = (NAME_SLOTS - 1 < 255) ? NAME_SLOTS - 1 : 255;
    localparam int RANDOM_ITEMS = 1250;
    // slowest legal run: ~1300 words, each with the longest idle gap, busy time and stall, stays well under this
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 40;

    // one request word as the driver holds it
    typedef struct packed {
        logic       opcode;
        entry_t     entry;
        logic [7:0] char_index;
    } dir_req_t;

    logic clk;
    logic rst_n;

    fde_req_if req_if ();
    fde_rsp_if rsp_if ();

    fat_directory_entry_decoder #(
        .NAME_SLOTS (NAME_SLOTS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Predicted decoder state: name RAM image, window and flags
    // ------------------------------------------------------------------
    logic [15:0] name_ram [NAME_SLOTS];
    int          name_base = 0;
    int          name_len  = 0;
    bit          lfn_open  = 1'b0;   // long-name parts collected, no 8.3 entry yet
    bit          dir_done  = 1'b0;   // end marker seen

    dir_req_t    pending_req_q [$];  // words not yet presented
    rsp_word_t   predicted_q   [$];  // results owed by the decoder
    dir_req_t    drv_item;
    rsp_word_t   want_word;
    int          err_count   = 0;
    int          sent_count  = 0;
    int          got_count   = 0;
    int          req_gap     = 0;
    int          rsp_stall   = 0;
    int          cycle_count = 0;

    // byte offset of unit i of a long-name part: 5 units at 1, 6 at 14, 2 at 28
    function automatic int unit_off(input int i);
        if (i < 5)
            return 1 + 2 * i;
        if (i < 11)
            return 14 + 2 * (i - 5);
        return 28 + 2 * (i - 11);
    endfunction

    // Expected result of one accepted word; updates the predicted state.
    function automatic rsp_word_t decode_entry_word(input dir_req_t r);
        rsp_word_t   res;
        entry_t      e;
        logic [7:0]  attr;
        logic [7:0]  b;
        logic [15:0] tm;
        logic [15:0] dt;
        logic [15:0] u;
        logic [15:0] part [LFN_UNITS];
        int          plen;
        int          total;
        int          trim_len;
        int          pos;
        int          c;
        res = '0;
        e   = r.entry;

        if (r.opcode == OP_READ)
        begin
            res.result_kind = KIND_CHAR;
            pos = name_base + int'(r.char_index);
            if (int'(r.char_index) < name_len && pos < NAME_SLOTS)
                res.name_char = name_ram[pos];
            return res;
        end

        // after the end marker every entry answers end, nothing changes
        if (dir_done)
        begin
            res.result_kind = KIND_END;
            return res;
        end
        if (e[7:0] == BYTE_END)
        begin
            dir_done        = 1'b1;
            res.result_kind = KIND_END;
            return res;
        end
        if (e[7:0] == BYTE_DELETED)
        begin
            res.result_kind = KIND_SKIP;
            return res;
        end

        attr = e[95:88];
        if (attr[3:0] == ATTR_LFN)
        begin
            // first 0 or 0xFFFF ends the part, whichever group it sits in
            plen = 0;
            for (c = 0; c < LFN_UNITS; c++)
            begin
                u = e[8 * unit_off(c) +: 16];
                if (u == UNIT_NUL || u == UNIT_FILL)
                    break;
                part[plen] = u;
                plen++;
            end
            if (!lfn_open)
            begin
                lfn_open  = 1'b1;
                name_len  = 0;
                name_base = NAME_CAP;
            end
            // prepend; a part that would overflow the name is dropped whole
            total = name_len + plen;
            if (total <= NAME_CAP)
            begin
                for (c = 0; c < plen; c++)
                    name_ram[NAME_CAP - total + c] = part[c];
                name_len  = total;
                name_base = NAME_CAP - total;
            end
            res.result_kind = KIND_SKIP;
            return res;
        end

        if (lfn_open)
            lfn_open = 1'b0;
        else
        begin
            // 8.3 name from slot 0: trailing pad trimmed, dot before a non-empty extension
            trim_len = 0;
            for (c = 0; c < 8; c++)
            begin
                b           = e[8 * c +: 8];
                name_ram[c] = {8'h00, b};
                if (b > BYTE_PAD)
                    trim_len = c + 1;
            end
            for (c = 0; c < 3; c++)
            begin
                b = e[8 * (8 + c) +: 8];
                if (b <= BYTE_PAD)
                    break;
                if (c == 0)
                begin
                    name_ram[trim_len] = UNIT_DOT;
                    trim_len++;
                end
                name_ram[trim_len] = {8'h00, b};
                trim_len++;
            end
            name_base = 0;
            name_len  = trim_len;
        end

        tm = e[8 * 22 +: 16];
        dt = e[8 * 24 +: 16];
        res.result_kind = KIND_FILE;
        res.attributes  = attr;
        res.file_size   = e[255:224];
        res.mod_day     = dt[4:0];
        res.mod_month   = dt[8:5];
        res.mod_year    = YEAR_BASE + 12'(dt[15:9]);
        res.mod_hours   = tm[15:11];
        res.mod_minutes = tm[10:5];
        res.mod_seconds = {tm[4:0], 1'b0};
        res.name_length = name_len[7:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic entry_t rand_entry();
        entry_t e;
        for (int i = 0; i < 8; i++)
            e[32 * i +: 32] = $urandom;
        return e;
    endfunction

    // random entry that is neither deleted nor the end marker
    function automatic entry_t noise_entry();
        entry_t e;
        e = rand_entry();
        if (e[7:0] == BYTE_END || e[7:0] == BYTE_DELETED)
            e[7:0] = 8'h41;
        return e;
    endfunction

    function automatic entry_t deleted_entry();
        entry_t e;
        e       = rand_entry();
        e[7:0]  = BYTE_DELETED;
        return e;
    endfunction

    // 8.3 entry; tidy ones have printable text padded with spaces
    function automatic entry_t short_entry(input bit tidy);
        entry_t e;
        int     nlen;
        int     xlen;
        e = noise_entry();
        if (tidy)
        begin
            nlen = $urandom_range(1, 8);
            xlen = $urandom_range(0, 3);
            for (int c = 0; c < 8; c++)
                e[8 * c +: 8] = (c < nlen) ? 8'($urandom_range(8'h21, 8'h7E)) : BYTE_PAD;
            for (int c = 0; c < 3; c++)
                e[8 * (8 + c) +: 8] = (c < xlen) ? 8'($urandom_range(8'h21, 8'h7E)) : BYTE_PAD;
            if (e[7:0] == BYTE_DELETED)
                e[7:0] = 8'h41;
        end
        if (e[91:88] == ATTR_LFN)
            e[91:88] = 4'($urandom_range(0, 14));
        return e;
    endfunction

    // long-name part of nunits units; a 0 or 0xFFFF stop unit follows if room
    function automatic entry_t lfn_entry(input int nunits, input bit fill_stop);
        entry_t      e;
        logic [15:0] u;
        e         = noise_entry();
        e[91:88]  = ATTR_LFN;
        for (int i = 0; i < LFN_UNITS; i++)
        begin
            if (i < nunits)
                u = 16'($urandom_range(1, 16'hFFFE));
            else if (i == nunits)
                u = fill_stop ? UNIT_FILL : UNIT_NUL;
            else
                u = 16'($urandom);
            e[8 * unit_off(i) +: 16] = u;
        end
        return e;
    endfunction

    task automatic push_entry(input entry_t e);
        dir_req_t r;
        r.opcode     = OP_ENTRY;
        r.entry      = e;
        r.char_index = 8'($urandom);
        pending_req_q.push_back(r);
    endtask

    task automatic push_read(input int idx);
        dir_req_t r;
        r.opcode     = OP_READ;
        r.entry      = rand_entry();
        r.char_index = 8'(idx);
        pending_req_q.push_back(r);
    endtask

    // often near the front of the name, some within its hinted length, some anywhere
    function automatic int read_index(input int hint);
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom_range(0, 15);
        if (r < 7)
            return $urandom_range(0, (hint > 255) ? 255 : hint);
        return $urandom_range(0, 255);
    endfunction

    // idle length: mostly short, a few long, none inside a calm stretch
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: one word at a time from pending_req_q. Each accepted
    // word is run through the predictor right at the accepting edge.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid       <= 1'b0;
            req_if.opcode      <= OP_ENTRY;
            req_if.entry_word0 <= '0;
            req_if.entry_word1 <= '0;
            req_if.entry_word2 <= '0;
            req_if.entry_word3 <= '0;
            req_if.char_index  <= '0;
            req_gap = 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                predicted_q.push_back(decode_entry_word(drv_item));
                sent_count++;
                req_gap = pick_gap((sent_count % 300) < 50);
            end
            // free to change the bus only when idle or just accepted
            if (!req_if.valid || req_if.ready)
            begin
                if (req_gap > 0)
                begin
                    req_gap--;
                    req_if.valid <= 1'b0;
                end
                else if (pending_req_q.size() > 0)
                begin
                    drv_item = pending_req_q.pop_front();
                    req_if.valid       <= 1'b1;
                    req_if.opcode      <= drv_item.opcode;
                    req_if.entry_word0 <= drv_item.entry[63:0];
                    req_if.entry_word1 <= drv_item.entry[127:64];
                    req_if.entry_word2 <= drv_item.entry[191:128];
                    req_if.entry_word3 <= drv_item.entry[255:192];
                    req_if.char_index  <= drv_item.char_index;
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Response monitor: stalls ready at random, checks each result word
    // against the oldest prediction.
    // ------------------------------------------------------------------
    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            rsp_stall = 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got_count++;
                if (predicted_q.size() == 0)
                begin
                    $error("result word with no prediction pending, kind %0d",
                           rsp_if.result_kind);
                    err_count++;
                end
                else
                begin
                    want_word = predicted_q.pop_front();
                    check_field("result_kind", want_word.result_kind, rsp_if.result_kind);
                    check_field("attributes",  want_word.attributes,  rsp_if.attributes);
                    check_field("file_size",   want_word.file_size,   rsp_if.file_size);
                    check_field("mod_day",     want_word.mod_day,     rsp_if.mod_day);
                    check_field("mod_month",   want_word.mod_month,   rsp_if.mod_month);
                    check_field("mod_year",    want_word.mod_year,    rsp_if.mod_year);
                    check_field("mod_hours",   want_word.mod_hours,   rsp_if.mod_hours);
                    check_field("mod_minutes", want_word.mod_minutes, rsp_if.mod_minutes);
                    check_field("mod_seconds", want_word.mod_seconds, rsp_if.mod_seconds);
                    check_field("name_length", want_word.name_length, rsp_if.name_length);
                    check_field("name_char",   want_word.name_char,   rsp_if.name_char);
                end
                rsp_stall = pick_gap((got_count % 220) < 40);
            end
            else if (rsp_stall == 0 && $urandom_range(0, 49) == 0)
                rsp_stall = pick_gap(1'b0);     // occasional stall while waiting

            if (rsp_stall > 0)
            begin
                rsp_stall--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        entry_t e;
        int     r;
        int     n;
        int     plen;
        int     hint;
        int     target;

        rst_n              = 1'b0;
        req_if.valid       = 1'b0;
        req_if.opcode      = OP_ENTRY;
        req_if.entry_word0 = '0;
        req_if.entry_word1 = '0;
        req_if.entry_word2 = '0;
        req_if.entry_word3 = '0;
        req_if.char_index  = '0;
        rsp_if.ready       = 1'b0;

        // --- directed part ---
        push_read(0);                       // empty name right after reset

        // "A" with all-space padding, every date/time field zero
        e = '0;
        e[7:0]   = 8'h41;
        e[87:8]  = {10{BYTE_PAD}};
        push_entry(e);
        push_read(0);
        push_read(1);

        // all ones: 12-unit name, every date/time field and size at maximum
        e = '1;
        e[95:88] = 8'hF0;
        push_entry(e);
        push_read(11);
        push_read(12);
        push_read(255);

        // blank base name with extension: ".TXT"
        e = '0;
        e[63:0]  = {8{BYTE_PAD}};
        e[87:64] = {8'h54, 8'h58, 8'h54};
        e[95:88] = 8'h20;
        push_entry(e);
        push_read(0);

        // control bytes inside the base name; extension starts with a pad, so none
        e = '0;
        e[63:0]  = {{4{BYTE_PAD}}, 8'h01, 8'h42, 8'h05, 8'h41};
        e[87:64] = {8'h41, 8'h41, BYTE_PAD};
        e[95:88] = 8'h10;
        push_entry(e);

        // deleted entry carrying long-name attributes
        e = '1;
        e[7:0] = BYTE_DELETED;
        push_entry(e);

        // long name from a full part, a part stopped by 0 at the head of the
        // middle group, and one stopped by 0xFFFF in the last group
        push_entry(lfn_entry(13, 1'b0));
        push_entry(lfn_entry(5, 1'b0));
        push_entry(lfn_entry(11, 1'b1));
        e = short_entry(1'b1);
        e[95:88] = 8'hEE;
        push_entry(e);
        push_read(0);
        push_read(28);
        push_read(29);

        // empty long name completes a file with length 0
        push_entry(lfn_entry(0, 1'b0));
        push_entry(short_entry(1'b1));
        push_read(0);

        // --- random part: mostly well-formed directories ---
        hint   = 0;
        target = pending_req_q.size() + RANDOM_ITEMS;
        while (pending_req_q.size() < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                // plain 8.3 file, maybe behind a deleted slot
                if ($urandom_range(0, 3) == 0)
                    push_entry(deleted_entry());
                push_entry(short_entry($urandom_range(0, 4) != 0));
                hint = 12;
                n = $urandom_range(0, 3);
                repeat (n) push_read(read_index(hint));
            end
            else if (r < 65)
            begin
                // long-name file of a few parts, reads possible mid-build
                n    = $urandom_range(1, 4);
                hint = 0;
                for (int k = 0; k < n; k++)
                begin
                    plen = ($urandom_range(0, 9) < 6) ? 13 : $urandom_range(0, 12);
                    push_entry(lfn_entry(plen, $urandom_range(0, 1)));
                    hint += plen;
                    if ($urandom_range(0, 7) == 0)
                        push_entry(deleted_entry());
                    if ($urandom_range(0, 7) == 0)
                        push_read(read_index(hint));
                end
                push_entry(short_entry($urandom_range(0, 3) != 0));
                n = $urandom_range(0, 3);
                repeat (n) push_read(read_index(hint));
            end
            else if (r < 70)
            begin
                // name that runs past the cap: trailing parts get dropped
                n    = $urandom_range(18, 23);
                hint = 0;
                for (int k = 0; k < n; k++)
                begin
                    plen = ($urandom_range(0, 9) < 7) ? 13 : $urandom_range(8, 12);
                    push_entry(lfn_entry(plen, $urandom_range(0, 1)));
                    hint += plen;
                end
                push_read($urandom_range(240, 255));
                push_read($urandom_range(0, 3));
                push_entry(short_entry(1'b1));
                push_read($urandom_range(240, 255));
                push_read(254);
                hint = 255;
            end
            else if (r < 82)
            begin
                n = $urandom_range(1, 4);
                repeat (n) push_read(read_index(hint));
            end
            else if (r < 90)
                push_entry(noise_entry());
            else
            begin
                // broken sequence: stray parts, then junk or a deleted slot
                n = $urandom_range(1, 2);
                repeat (n) push_entry(lfn_entry($urandom_range(0, 13), $urandom_range(0, 1)));
                if ($urandom_range(0, 1) == 0)
                    push_entry(noise_entry());
                else
                    push_entry(deleted_entry());
                hint = 40;
            end
        end

        // --- end marker, then everything answers end; reads keep working ---
        e = rand_entry();
        e[7:0] = BYTE_END;
        push_entry(e);
        push_entry(lfn_entry(13, 1'b0));
        push_entry(short_entry(1'b1));
        push_entry(deleted_entry());
        push_entry(noise_entry());
        push_read(0);
        push_read(read_index(hint));
        push_read(255);
        e = rand_entry();
        e[7:0] = BYTE_END;
        push_entry(e);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_req_q.size() != 0 || predicted_q.size() != 0 || req_if.valid)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (predicted_q.size() != 0)
        begin
            $error("%0d predicted result words never arrived", predicted_q.size());
            err_count++;
        end
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
rtl/core/fde_pkg.sv
rtl/core/fde_if.sv
rtl/core/fde_ram.sv
rtl/core/fat_directory_entry_decoder.sv
verif/fat_directory_entry_decoder_tb.sv
